/* hw/rtl/sowm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sowm_pkg: shared types and codes for the spool output well manager
// Command and result beat layouts, status and mode codes, sequencer states.
// ----------------------------------------------------------------------------
package sowm_pkg;

	// default sizing
	localparam int SOWM_WELL_DEPTH   = 32;
	localparam int SOWM_DESC_SLOTS   = 16;
	localparam int SOWM_MAX_FILE_LEN = 32;

	// command modes
	localparam logic [1:0] MODE_HDR   = 2'd0;
	localparam logic [1:0] MODE_DATA  = 2'd1;
	localparam logic [1:0] MODE_SPOOL = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ADMIT   = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_NOROOM  = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_IDLE    = 3'd4;
	localparam logic [2:0] ST_WORD    = 3'd5;
	localparam logic [2:0] ST_STRAY   = 3'd6;

	// producer states
	localparam logic [1:0] PS_RUN   = 2'd0;
	localparam logic [1:0] PS_FULL  = 2'd1;
	localparam logic [1:0] PS_EMPTY = 2'd2;

	// input beat
	typedef struct packed {
		logic [1:0] mode;
		logic       requester;
		logic [5:0] file_length;
		logic [7:0] word_in;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic [2:0] status;
		logic       owner;
		logic [7:0] word_out;
		logic       last_word;
		logic [1:0] producer0_state;
		logic [1:0] producer1_state;
		logic [4:0] queued_files;
	} res_t;

	// well port controls
	typedef struct packed {
		logic wr_en;
		logic wr_own;
		logic rd_en;
		logic rd_own;
	} well_ctl_t;

	// sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_DESC,
		FSM_WORDS
	} fsm_t;

endpackage

/* hw/rtl/sowm_well.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sowm_well: output well storage for both producers
// One write and one registered read port; producer number picks the half.
// ----------------------------------------------------------------------------
module sowm_well
	import sowm_pkg::*;
#(
	parameter int WELL_DEPTH = SOWM_WELL_DEPTH
) (
	input  logic                          clk,
	input  well_ctl_t                     ctl,
	input  logic [$clog2(WELL_DEPTH)-1:0] wr_ptr,
	input  logic [7:0]                    wr_data,
	input  logic [$clog2(WELL_DEPTH)-1:0] rd_ptr,
	output logic [7:0]                    rd_data
);

	localparam int AW = $clog2(2 * WELL_DEPTH);

	logic [7:0]    mem [2 * WELL_DEPTH];
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	// producer 1 owns the upper half
	assign wr_addr = ctl.wr_own ? AW'(WELL_DEPTH) + AW'(wr_ptr) : AW'(wr_ptr);
	assign rd_addr = ctl.rd_own ? AW'(WELL_DEPTH) + AW'(rd_ptr) : AW'(rd_ptr);

	// read returns the old word when both ports hit one entry
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/spool_output_well_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spool_output_well_manager: two-producer output spooler
// Admits file requests into per-producer wells and a shared descriptor ring,
// takes data words, and spools the oldest complete file one word a beat.
// ----------------------------------------------------------------------------
//
// channel   ports                 handshake
// -------   -------------------   ------------------------------------
// command   cmd (cmd_t)           taken at clk edge with start && !busy
// result    result (res_t)        valid for one cycle while strobe high
//
// Header, data word, idle spool or unknown mode: handled from idle, result
// registered at the accepting edge. A spool of an L-word file holds busy
// through one descriptor ring read, then one well read per word, and emits
// one word beat per cycle. Reset is asynchronous; no clearing pass, both
// memories are used only where written. The receiver cannot stall.
// ----------------------------------------------------------------------------
module spool_output_well_manager
	import sowm_pkg::*;
#(
	parameter int WELL_DEPTH   = SOWM_WELL_DEPTH,
	parameter int DESC_SLOTS   = SOWM_DESC_SLOTS,
	parameter int MAX_FILE_LEN = SOWM_MAX_FILE_LEN
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic strobe,
	output res_t result
);

	localparam int PW      = $clog2(WELL_DEPTH);
	localparam int FW      = $clog2(WELL_DEPTH + 1);
	localparam int LW      = $clog2(MAX_FILE_LEN + 1);
	localparam int XW      = ((FW > LW) ? FW : LW) + 1;
	localparam int IW      = $clog2(DESC_SLOTS);
	localparam int CW      = IW + 1;
	localparam int CNT_MOD = 2 * DESC_SLOTS;
	localparam int DW      = 1 + LW + PW;

	// counter helpers, modulo 2 * DESC_SLOTS; ptr_inc wraps at WELL_DEPTH
	function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
		logic [CW-1:0] r;
		r = (c == CW'(CNT_MOD - 1)) ? '0 : c + CW'(1);
		return r;
	endfunction

	function automatic logic [IW-1:0] cnt_idx(input logic [CW-1:0] c);
		logic [CW-1:0] r;
		r = (c >= CW'(DESC_SLOTS)) ? c - CW'(DESC_SLOTS) : c;
		return r[IW-1:0];
	endfunction

	function automatic logic [CW-1:0] cnt_diff(input logic [CW-1:0] a,
		input logic [CW-1:0] s);
		logic [CW:0] r;
		r = (a >= s) ? {1'b0, a} - {1'b0, s} : {1'b0, a} + (CW + 1)'(CNT_MOD) - {1'b0, s};
		return r[CW-1:0];
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(WELL_DEPTH - 1)) ? '0 : p + PW'(1);
		return r;
	endfunction

	// state
	fsm_t          state_q, state_d;
	logic [PW-1:0] end_q [2];
	logic [PW-1:0] end_d [2];
	logic [FW-1:0] fill_q [2];
	logic [FW-1:0] fill_d [2];
	logic [1:0]    pst_q [2];
	logic [1:0]    pst_d [2];
	logic [CW-1:0] admit_q, admit_d;
	logic [CW-1:0] spool_q, spool_d;
	logic [LW-1:0] orem_q, orem_d;
	logic [PW-1:0] optr_q, optr_d;
	logic          oown_q, oown_d;
	logic          sp_own_q, sp_own_d;
	logic [PW-1:0] sp_ptr_q, sp_ptr_d;
	logic [LW-1:0] sp_left_q, sp_left_d;
	logic          strobe_q, strobe_d;
	res_t          res_q, res_d;

	// descriptor ring memory
	logic [DW-1:0] ring [DESC_SLOTS];
	logic [DW-1:0] ring_rd_q;
	logic          ring_we;
	logic          ring_re;
	logic [DW-1:0] ring_wdata;

	// well port
	well_ctl_t     well_ctl;
	logic [PW-1:0] well_wr_ptr;
	logic [7:0]    well_wr_data;
	logic [PW-1:0] well_rd_ptr;
	logic [7:0]    well_rd_data;

	// decode
	logic          accept;
	logic          req;
	logic [6:0]    flen7;
	logic [6:0]    flen_c7;
	logic [LW-1:0] flen;
	logic [FW-1:0] room;
	logic [XW-1:0] end_sum;
	logic [CW-1:0] q_now;
	logic [CW-1:0] q_next;
	logic          d_own;
	logic [LW-1:0] d_len;
	logic [PW-1:0] d_addr;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;
	assign req    = cmd.requester;

	// clamp length to 1..MAX_FILE_LEN
	assign flen7   = {1'b0, cmd.file_length};
	assign flen_c7 = (flen7 == 7'd0) ? 7'd1 :
		((flen7 > 7'(MAX_FILE_LEN)) ? 7'(MAX_FILE_LEN) : flen7);
	assign flen    = flen_c7[LW-1:0];

	assign room    = FW'(WELL_DEPTH) - fill_q[req];
	assign end_sum = XW'(end_q[req]) + XW'(flen);
	assign q_now   = cnt_diff(admit_q, spool_q);
	assign q_next  = cnt_diff(admit_d, spool_d);

	// descriptor fields: owner, length, start address
	assign d_own  = ring_rd_q[DW-1];
	assign d_len  = ring_rd_q[PW +: LW];
	assign d_addr = ring_rd_q[PW-1:0];

	// next state, memory controls and result
	always_comb begin
		state_d      = state_q;
		end_d        = end_q;
		fill_d       = fill_q;
		pst_d        = pst_q;
		admit_d      = admit_q;
		spool_d      = spool_q;
		orem_d       = orem_q;
		optr_d       = optr_q;
		oown_d       = oown_q;
		sp_own_d     = sp_own_q;
		sp_ptr_d     = sp_ptr_q;
		sp_left_d    = sp_left_q;
		strobe_d     = 1'b0;
		ring_we      = 1'b0;
		ring_re      = 1'b0;
		ring_wdata   = {req, flen, end_q[req]};
		well_ctl     = '0;
		well_wr_ptr  = optr_q;
		well_wr_data = cmd.word_in;
		well_rd_ptr  = sp_ptr_q;
		res_d        = '0;
		res_d.status = ST_STRAY;

		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					strobe_d = 1'b1;
					case (cmd.mode)
						MODE_HDR: begin
							res_d.owner = req;
							if (orem_q != '0 || pst_q[req] != PS_RUN) begin
								res_d.status = ST_BLOCKED;
							end else if (q_now >= CW'(DESC_SLOTS)) begin
								pst_d[req]   = PS_FULL;
								res_d.status = ST_FULL;
							end else if (XW'(room) < XW'(flen)) begin
								pst_d[req]   = PS_EMPTY;
								res_d.status = ST_NOROOM;
							end else begin
								ring_we      = 1'b1;
								orem_d       = flen;
								optr_d       = end_q[req];
								oown_d       = req;
								end_d[req]   = (end_sum >= XW'(WELL_DEPTH)) ?
									PW'(end_sum - XW'(WELL_DEPTH)) : PW'(end_sum);
								fill_d[req]  = fill_q[req] + FW'(flen);
								res_d.status = ST_ADMIT;
							end
						end
						MODE_DATA: begin
							if (orem_q == '0) begin
								res_d.status = ST_STRAY;
							end else begin
								well_ctl.wr_en  = 1'b1;
								well_ctl.wr_own = oown_q;
								optr_d          = ptr_inc(optr_q);
								orem_d          = orem_q - LW'(1);
								if (orem_q == LW'(1)) begin
									admit_d = cnt_inc(admit_q);
								end
								res_d.status = ST_ADMIT;
								res_d.owner  = oown_q;
							end
						end
						MODE_SPOOL: begin
							if (q_now == '0) begin
								res_d.status = ST_IDLE;
							end else begin
								strobe_d = 1'b0;
								ring_re  = 1'b1;
								state_d  = FSM_DESC;
							end
						end
						default: begin
							res_d.status = ST_STRAY;
						end
					endcase
				end
			end
			FSM_DESC: begin
				// first word read and clear, space freed, producers released
				well_ctl.rd_en  = 1'b1;
				well_ctl.rd_own = d_own;
				well_ctl.wr_en  = 1'b1;
				well_ctl.wr_own = d_own;
				well_rd_ptr     = d_addr;
				well_wr_ptr     = d_addr;
				well_wr_data    = 8'd0;
				sp_own_d        = d_own;
				sp_ptr_d        = ptr_inc(d_addr);
				sp_left_d       = d_len;
				fill_d[d_own]   = (XW'(fill_q[d_own]) >= XW'(d_len)) ?
					fill_q[d_own] - FW'(d_len) : '0;
				spool_d         = cnt_inc(spool_q);
				pst_d[0]        = PS_RUN;
				pst_d[1]        = PS_RUN;
				state_d         = FSM_WORDS;
			end
			FSM_WORDS: begin
				strobe_d        = 1'b1;
				res_d.status    = ST_WORD;
				res_d.owner     = sp_own_q;
				res_d.word_out  = well_rd_data;
				res_d.last_word = (sp_left_q == LW'(1));
				if (sp_left_q > LW'(1)) begin
					well_ctl.rd_en  = 1'b1;
					well_ctl.rd_own = sp_own_q;
					well_ctl.wr_en  = 1'b1;
					well_ctl.wr_own = sp_own_q;
					well_rd_ptr     = sp_ptr_q;
					well_wr_ptr     = sp_ptr_q;
					well_wr_data    = 8'd0;
					sp_ptr_d        = ptr_inc(sp_ptr_q);
					sp_left_d       = sp_left_q - LW'(1);
				end else begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase

		// states and queue depth as they stand after the item
		res_d.producer0_state = pst_d[0];
		res_d.producer1_state = pst_d[1];
		res_d.queued_files    = 5'(q_next);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q     <= '{default: '0};
			fill_q    <= '{default: '0};
			pst_q     <= '{default: PS_RUN};
			admit_q   <= '0;
			spool_q   <= '0;
			orem_q    <= '0;
			optr_q    <= '0;
			oown_q    <= 1'b0;
			sp_left_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			end_q     <= end_d;
			fill_q    <= fill_d;
			pst_q     <= pst_d;
			admit_q   <= admit_d;
			spool_q   <= spool_d;
			orem_q    <= orem_d;
			optr_q    <= optr_d;
			oown_q    <= oown_d;
			sp_left_q <= sp_left_d;
			strobe_q  <= strobe_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		sp_own_q <= sp_own_d;
		sp_ptr_q <= sp_ptr_d;
		res_q    <= res_d;
	end

	// descriptor ring: write at admit slot, registered read at spool slot
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[cnt_idx(admit_q)] <= ring_wdata;
		end
		if (ring_re) begin
			ring_rd_q <= ring[cnt_idx(spool_q)];
		end
	end

	sowm_well #(
		.WELL_DEPTH(WELL_DEPTH)
	) u_well (
		.clk     (clk),
		.ctl     (well_ctl),
		.wr_ptr  (well_wr_ptr),
		.wr_data (well_wr_data),
		.rd_ptr  (well_rd_ptr),
		.rd_data (well_rd_data)
	);

	assign strobe = strobe_q;
	assign result = res_q;

	// checks
	a_desc_then_words: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DESC |=> state_q == FSM_WORDS)
		else $error("descriptor fetch not followed by word output");

	a_words_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_WORDS |-> sp_left_q != '0)
		else $error("word output with no words left");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_now <= CW'(DESC_SLOTS))
		else $error("descriptor queue over capacity");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= FW'(WELL_DEPTH) && fill_q[1] <= FW'(WELL_DEPTH))
		else $error("well fill over depth");

	a_last_is_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && res_q.last_word |-> res_q.status == ST_WORD && $past(state_q) == FSM_WORDS)
		else $error("last word flag outside spool output");

endmodule
